// ----- sv/tst_pkg.sv -----
`default_nettype none

package tst_pkg;

    // Default sizing of the slot table
    localparam int NUM_SLOTS_DEF  = 20;
    localparam int TIME_WIDTH_DEF = 16;

    // Fixed field widths on the channels
    localparam int REQ_W    = 3;
    localparam int SLOT_W   = 6;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_PERIOD = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_KILL_ALL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd4;

    // One result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic [FIELD_W-1:0]  period_out;
        logic                last;
    } rsp_t;

    // Flags from the slot decrement unit
    typedef struct packed {
        logic expired;
        logic free_slot;
    } dec_flags_t;

endpackage

`default_nettype wire

// ----- sv/tst_req_if.sv -----
`default_nettype none

interface tst_req_if
    import tst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  slot_number;
    logic [FIELD_W-1:0] period_ticks;
    logic [FIELD_W-1:0] first_delay;

    modport source (
        output valid, req_type, slot_number, period_ticks, first_delay,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot_number, period_ticks, first_delay,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/tst_rsp_if.sv -----
`default_nettype none

interface tst_rsp_if
    import tst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [FIELD_W-1:0]  period_out;
    logic                last;

    modport source (
        output valid, status, slot_out, period_out, last,
        input  ready
    );

    modport sink (
        input  valid, status, slot_out, period_out, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/tst_dec_unit.sv -----
`default_nettype none

// Shared slot unit: decrement one counter with wraparound, detect expiry,
// pick the reload value and decide whether a one-shot slot is released.
module tst_dec_unit
    import tst_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  busy,
    input  wire logic [TIME_WIDTH-1:0] count,
    input  wire logic [TIME_WIDTH-1:0] period,
    output      logic [TIME_WIDTH-1:0] count_new,
    output      dec_flags_t            flags
);

    logic [TIME_WIDTH-1:0] dec;
    logic                  hit;

    assign dec = count - TIME_WIDTH'(1);
    assign hit = busy && (dec == '0);

    // reload on expiry, otherwise keep the decremented value
    assign count_new       = hit ? period : dec;
    assign flags.expired   = hit;
    assign flags.free_slot = hit && (period == '0);

endmodule

`default_nettype wire

// ----- sv/tst_out_stage.sv -----
`default_nettype none

// One-entry output register between the sequencer and the result channel.
module tst_out_stage
    import tst_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    input  wire rsp_t  push_data,
    output      logic  push_ready,
    tst_rsp_if.source  rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign push_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds while the beat waits
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            data_reg <= push_data;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.status     = data_reg.status;
    assign rsp.slot_out   = data_reg.slot_out;
    assign rsp.period_out = data_reg.period_out;
    assign rsp.last       = data_reg.last;

endmodule

`default_nettype wire

// ----- sv/periodic_timer_slot_table.sv -----
`default_nettype none

// Channel  Dir  Beat contents
// -------  ---  -------------------------------------------------------
// req      in   req_type, slot_number, period_ticks, first_delay
// rsp      out  status, slot_out, period_out, last
//
// Set period, cancel and kill all answer with one result beat; register walks
// the slots one per cycle for the lowest free one; a tick walks all NUM_SLOTS
// slots through the shared decrement unit, then sends its final beat, if any.
// req is ready only between requests. A stalled rsp holds the walk on the next
// expiring slot. Reset (rst_n, asynchronous) frees every slot at once; periods
// and counters are not cleared.
module periodic_timer_slot_table
    import tst_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tst_req_if.sink   req,
    tst_rsp_if.source rsp
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REG  = 3'd1;
    localparam logic [2:0] S_TICK = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      idx_next;
    logic [TIME_WIDTH-1:0] per_reg;
    logic [TIME_WIDTH-1:0] per_next;
    logic [TIME_WIDTH-1:0] dly_reg;
    logic [TIME_WIDTH-1:0] dly_next;
    rsp_t                  res_reg;
    rsp_t                  res_next;
    rsp_t                  pend_reg;
    rsp_t                  pend_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [NUM_SLOTS-1:0]  busy_reg;
    logic [NUM_SLOTS-1:0]  busy_next;

    logic [TIME_WIDTH-1:0] slot_period_reg [NUM_SLOTS];
    logic [TIME_WIDTH-1:0] slot_count_reg  [NUM_SLOTS];

    logic [IDX_W-1:0]      idx;
    logic                  walk_end;
    logic                  cur_busy;
    logic [TIME_WIDTH-1:0] cur_count;
    logic [TIME_WIDTH-1:0] cur_period;
    logic [TIME_WIDTH-1:0] count_new;
    dec_flags_t            flags;

    logic                  per_we;
    logic [IDX_W-1:0]      per_waddr;
    logic [TIME_WIDTH-1:0] per_wdata;
    logic                  cnt_we;
    logic [TIME_WIDTH-1:0] cnt_wdata;

    logic                  push_valid;
    rsp_t                  push_data;
    logic                  push_ready;
    logic                  bad_slot;
    logic [IDX_W-1:0]      req_idx;

    assign idx        = idx_reg[IDX_W-1:0];
    assign walk_end   = (idx_reg == CNT_W'(NUM_SLOTS));
    assign cur_busy   = busy_reg[idx];
    assign cur_count  = slot_count_reg[idx];
    assign cur_period = slot_period_reg[idx];
    assign bad_slot   = ({1'b0, req.slot_number} >= (SLOT_W + 1)'(NUM_SLOTS));
    assign req_idx    = req.slot_number[IDX_W-1:0];
    assign req.ready  = (state_reg == S_IDLE);

    tst_dec_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dec (
        .busy      (cur_busy),
        .count     (cur_count),
        .period    (cur_period),
        .count_new (count_new),
        .flags     (flags)
    );

    tst_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .rsp        (rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        per_next        = per_reg;
        dly_next        = dly_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        busy_next       = busy_reg;
        per_we          = 1'b0;
        per_waddr       = idx;
        per_wdata       = per_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = dly_reg;
        push_valid      = 1'b0;
        push_data       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next.period_out = '0;
                    res_next.last       = 1'b1;
                    case (req.req_type)
                        REQ_REGISTER:
                        begin
                            per_next   = TIME_WIDTH'(req.period_ticks);
                            dly_next   = TIME_WIDTH'(req.first_delay);
                            idx_next   = '0;
                            state_next = S_REG;
                        end
                        REQ_SET_PERIOD, REQ_CANCEL:
                        begin
                            res_next.slot_out = req.slot_number;
                            if (bad_slot)
                            begin
                                res_next.status = ST_BAD_SLOT;
                            end
                            else
                            begin
                                res_next.status = ST_ACCEPTED;
                                if (req.req_type == REQ_SET_PERIOD)
                                begin
                                    per_we    = 1'b1;
                                    per_waddr = req_idx;
                                    per_wdata = TIME_WIDTH'(req.period_ticks);
                                end
                                else
                                begin
                                    busy_next[req_idx] = 1'b0;
                                end
                            end
                            state_next = S_PUSH;
                        end
                        REQ_KILL_ALL:
                        begin
                            busy_next         = '0;
                            res_next.status   = ST_ACCEPTED;
                            res_next.slot_out = '0;
                            state_next        = S_PUSH;
                        end
                        REQ_TICK:
                        begin
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TICK;
                        end
                        default:
                        begin
                            // unused codes: no result
                        end
                    endcase
                end
            end

            // look for the lowest free slot
            S_REG:
            begin
                res_next.period_out = '0;
                res_next.last       = 1'b1;
                if (walk_end)
                begin
                    res_next.status   = ST_TABLE_FULL;
                    res_next.slot_out = '0;
                    state_next        = S_PUSH;
                end
                else if (!cur_busy)
                begin
                    busy_next[idx]    = 1'b1;
                    per_we            = 1'b1;
                    cnt_we            = 1'b1;
                    res_next.status   = ST_REGISTERED;
                    res_next.slot_out = SLOT_W'(idx);
                    state_next        = S_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // walk all slots; each expiry is held until the next one or the end
            S_TICK:
            begin
                if (walk_end)
                begin
                    if (pend_valid_reg)
                    begin
                        push_valid     = 1'b1;
                        push_data      = pend_reg;
                        push_data.last = 1'b1;
                        if (push_ready)
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (cur_busy)
                begin
                    if (flags.expired && pend_valid_reg)
                    begin
                        push_valid     = 1'b1;
                        push_data      = pend_reg;
                        push_data.last = 1'b0;
                    end
                    if (!(flags.expired && pend_valid_reg) || push_ready)
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = count_new;
                        if (flags.free_slot)
                        begin
                            busy_next[idx] = 1'b0;
                        end
                        if (flags.expired)
                        begin
                            pend_next.status     = ST_EXPIRED;
                            pend_next.slot_out   = SLOT_W'(idx);
                            pend_next.period_out = FIELD_W'(cur_period);
                            pend_next.last       = 1'b0;
                            pend_valid_next      = 1'b1;
                        end
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            // single result of a non-tick request
            S_PUSH:
            begin
                push_valid = 1'b1;
                push_data  = res_reg;
                if (push_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            busy_reg       <= busy_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        per_reg  <= per_next;
        dly_reg  <= dly_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

    // Slot period and counter storage
    always_ff @(posedge clk)
    begin
        if (per_we)
        begin
            slot_period_reg[per_waddr] <= per_wdata;
        end
        if (cnt_we)
        begin
            slot_count_reg[idx] <= cnt_wdata;
        end
    end

endmodule

`default_nettype wire
